FILE: rtl/cdq_pkg.sv
package cdq_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned OccW  = 5;
	localparam int unsigned CapW  = 5;
	localparam logic [CapW-1:0] CapReset = 5'd16;

	typedef enum logic [1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_REAR  = 2'd1,
		CMD_DEL_FRONT = 2'd2,
		CMD_DEL_REAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

FILE: rtl/cdq_ram.sv
module cdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/circular_double_ended_queue_unit.sv
// Channel   Handshake            Payload
// command   start / busy         command, insert_value
// result    done (strobe)        removed_value, status, occupancy
// config    cfg_write            cfg_data (capacity, clamped to 1..DEPTH)
//
// A command is taken in every cycle; busy stays low. Its result strobes on
// done in the cycle after the command beat, once the slot RAM's registered
// read port has returned a deleted element.
// Reset empties the queue and sets capacity to 16; no clearing pass.
// A capacity write empties the queue. The receiver cannot stall results.
module circular_double_ended_queue_unit #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic signed [31:0]        insert_value,
	output logic                      done,
	output logic signed [31:0]        removed_value,
	output logic [1:0]                status,
	output logic [4:0]                occupancy,
	input  logic                      cfg_write,
	input  logic [4:0]                cfg_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = (CW > cdq_pkg::CapW) ? CW : cdq_pkg::CapW;

	logic [cdq_pkg::CapW-1:0] capacity_q;
	logic [AW-1:0]            head_q, tail_q, head_d, tail_d;
	logic [CW-1:0]            count_q, count_d;
	logic [EW-1:0]            cap_ext;
	logic [CW-1:0]            cap_eff;
	logic [AW-1:0]            head_next, head_prev, tail_next, tail_prev;

	logic                     accept;
	cdq_pkg::cmd_t            cmd;
	cdq_pkg::status_t         status_d;
	logic                     del_ok_d;

	logic                     ram_we, ram_re;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [cdq_pkg::DataW-1:0] ram_rdata;

	logic                     done_s1;
	logic                     del_ok_s1;
	cdq_pkg::status_t         status_s1;
	logic [cdq_pkg::OccW-1:0] occ_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign cmd    = cdq_pkg::cmd_t'(command);

	always_comb begin
		cap_ext = EW'(capacity_q);
		if (cap_ext == '0) begin
			cap_ext = EW'(1);
		end else if (cap_ext > EW'(DEPTH)) begin
			cap_ext = EW'(DEPTH);
		end
		cap_eff = CW'(cap_ext);
	end

	// ring step within the live capacity, not the full depth
	assign head_next = ((CW'(head_q) + CW'(1)) >= cap_eff) ? '0 : head_q + AW'(1);
	assign tail_next = ((CW'(tail_q) + CW'(1)) >= cap_eff) ? '0 : tail_q + AW'(1);
	assign head_prev = (head_q == '0) ? AW'(cap_eff - CW'(1)) : head_q - AW'(1);
	assign tail_prev = (tail_q == '0) ? AW'(cap_eff - CW'(1)) : tail_q - AW'(1);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = '0;
		ram_raddr = '0;
		status_d  = cdq_pkg::ST_DONE;
		del_ok_d  = 1'b0;
		if (accept) begin
			unique case (cmd)
				cdq_pkg::CMD_INS_FRONT, cdq_pkg::CMD_INS_REAR: begin
					if (count_q >= cap_eff) begin
						status_d = cdq_pkg::ST_FULL;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + CW'(1);
						if (count_q == '0) begin
							head_d    = '0;
							tail_d    = '0;
							ram_waddr = '0;
						end else if (cmd == cdq_pkg::CMD_INS_FRONT) begin
							head_d    = head_prev;
							ram_waddr = head_prev;
						end else begin
							tail_d    = tail_next;
							ram_waddr = tail_next;
						end
					end
				end
				cdq_pkg::CMD_DEL_FRONT, cdq_pkg::CMD_DEL_REAR: begin
					if (count_q == '0) begin
						status_d = cdq_pkg::ST_EMPTY;
					end else begin
						ram_re   = 1'b1;
						del_ok_d = 1'b1;
						count_d  = count_q - CW'(1);
						if (cmd == cdq_pkg::CMD_DEL_FRONT) begin
							ram_raddr = head_q;
							head_d    = head_next;
						end else begin
							ram_raddr = tail_q;
							tail_d    = tail_prev;
						end
						if (count_q == CW'(1)) begin
							head_d = '0;
							tail_d = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	cdq_ram #(
		.WIDTH(cdq_pkg::DataW),
		.DEPTH(DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (insert_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cdq_pkg::CapReset;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			done_s1    <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (cfg_write) begin
				capacity_q <= cfg_data;
				head_q     <= '0;
				tail_q     <= '0;
				count_q    <= '0;
			end else begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		del_ok_s1 <= del_ok_d;
		status_s1 <= status_d;
		occ_s1    <= cdq_pkg::OccW'(count_d);
	end

	assign done          = done_s1;
	assign status        = status_s1;
	assign occupancy     = occ_s1;
	assign removed_value = del_ok_s1 ? $signed(ram_rdata) : 32'sd0;

	a_result_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept))
		else $error("result strobe not one cycle after command beat");

	a_count_in_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("element count above capacity");

	a_empty_ends_home: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty queue with ends off slot zero");

	a_refused_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != cdq_pkg::ST_DONE) |-> (removed_value == 32'sd0))
		else $error("refused command returned a value");

endmodule
